// ===== hw/rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table search package
// Stream widths, field positions, command codes and sequencer states shared
// by the search block and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  // Input transaction fields in tdata, lowest bit first
  localparam int unsigned IdxW       = 10;
  localparam int unsigned ValW       = 32;
  localparam int unsigned S_TDATA_W  = 96;
  localparam int unsigned M_TDATA_W  = 16;

  localparam int unsigned EntryIdxLsb = 0;
  localparam int unsigned EntryValLsb = EntryIdxLsb + IdxW;
  localparam int unsigned LowLsb      = EntryValLsb + ValW;
  localparam int unsigned HighLsb     = LowLsb + IdxW;
  localparam int unsigned KeyLsb      = HighLsb + IdxW;

  // Command carried in tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic signed [ValW-1:0] val_t;
  // Search bounds: room for midpoint + 1 and midpoint - 1
  typedef logic signed [IdxW+1:0] bound_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_table_binary_search.sv =====
// A write transaction is taken without leaving the idle state. A search runs k probes, each
// a registered table read then a compare; it ends on a hit, or on a miss once the range is
// empty, and k is at most 11 for 1024 entries. The single table read port sets the probe
// rate; the next transaction is taken only after the search result has been loaded into the
// output register, which waits while an earlier result is stalled.
// Reset clears the sequencer and the output valid; table contents are undefined until written.
// ----------------------------------------------------------------------------
// Sorted table binary search
// Table of signed 32-bit entries loaded by write transactions; search
// transactions run a binary search over an inclusive index range.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // [9:0] entry_index, [41:10] entry_value, [51:42] low_bound,
  // [61:52] high_bound, [93:62] search_key, [95:94] zero
  input  wire logic [sts_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] cmd
  input  wire logic                           s_axis_tuser_i,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [9:0] found_index, [15:10] zero
  output      logic [sts_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // [0] found
  output      logic                           m_axis_tuser_o
);

  import sts_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = (AW > IdxW) ? AW : IdxW;
  localparam logic [16:0] DepthW = 17'(TABLE_DEPTH);
  localparam idx_t        LastIdx = IdxW'(TABLE_DEPTH - 1);

  state_e state_d, state_q;

  idx_t   in_entry_idx, in_low, in_high, high_clamped;
  val_t   in_entry_val, in_key;

  bound_t lo_q, lo_d, hi_q, hi_d;
  bound_t bound_sum;
  val_t   key_q, key_d;
  val_t   rdata_q;
  idx_t   mid, mid_q;
  logic   res_found_q, res_found_d;
  idx_t   res_idx_q, res_idx_d;

  logic   s_hs, wr_en, rd_en, out_load;
  logic [IW-1:0] wr_addr_ext, rd_addr_ext;

  val_t   table_mem [TABLE_DEPTH];

  assign in_entry_idx = s_axis_tdata_i[EntryIdxLsb +: IdxW];
  assign in_entry_val = s_axis_tdata_i[EntryValLsb +: ValW];
  assign in_low       = s_axis_tdata_i[LowLsb +: IdxW];
  assign in_high      = s_axis_tdata_i[HighLsb +: IdxW];
  assign in_key       = s_axis_tdata_i[KeyLsb +: ValW];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs            = s_axis_tvalid_i & s_axis_tready_o;

  // clamp the upper bound to the last table entry
  assign high_clamped = ({7'b0, in_high} >= DepthW) ? LastIdx : in_high;

  assign bound_sum = lo_q + hi_q;
  assign mid       = bound_sum[IdxW:1];

  assign wr_en       = s_hs && (s_axis_tuser_i == CMD_WRITE) && ({7'b0, in_entry_idx} < DepthW);
  assign wr_addr_ext = IW'(in_entry_idx);
  assign rd_en       = (state_q == ST_PROBE) && (lo_q <= hi_q);
  assign rd_addr_ext = IW'(mid);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr_ext[AW-1:0]] <= in_entry_val;
    end
    if (rd_en) begin
      rdata_q <= table_mem[rd_addr_ext[AW-1:0]];
    end
  end

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_hs && (s_axis_tuser_i == CMD_SEARCH)) begin
          lo_d    = bound_t'(in_low);
          hi_d    = bound_t'(high_clamped);
          key_d   = in_key;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_q > hi_q) begin
          res_found_d = 1'b0;
          res_idx_d   = '0;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rdata_q == key_q) begin
          res_found_d = 1'b1;
          res_idx_d   = mid_q;
          state_d     = ST_DONE;
        end else begin
          if (key_q > rdata_q) begin
            lo_d = bound_t'(mid_q) + bound_t'(1);
          end else begin
            hi_d = bound_t'(mid_q) - bound_t'(1);
          end
          state_d = ST_PROBE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_DONE) && (!m_axis_tvalid_o || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      m_axis_tvalid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_axis_tvalid_o <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_axis_tvalid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    if (rd_en) begin
      mid_q <= mid;
    end
    if (out_load) begin
      m_axis_tuser_o <= res_found_q;
      m_axis_tdata_o <= M_TDATA_W'(res_idx_q);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sts_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted table search port checker
// Watches the stream ports of the search block and flags misbehaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic                           s_axis_tuser_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [sts_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input wire logic                           m_axis_tuser_o
);

  import sts_pkg::*;

  // stalled result must stay put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a miss reports index zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("miss with non-zero index");

  // a write completes in its own cycle
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == CMD_WRITE) |=> s_axis_tready_o)
    else $error("write stalled the input");

  // a search takes the input out of ready straight after it is accepted
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == CMD_SEARCH) |=> !s_axis_tready_o)
    else $error("input ready straight after a search");

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
